FILE: rtl/dmlc_pkg.sv
// ----------------------------------------------------------------------------
// dmlc_pkg
// Shared types and codes for the door motor limit controller.
// ----------------------------------------------------------------------------
package dmlc_pkg;

  localparam int CNT_W = 15;
  localparam int CFG_ADDR_W = 2;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t REG_BRAKE_DELAY = 2'd0;
  localparam cfg_addr_t REG_MAX_RUN     = 2'd1;
  localparam cfg_addr_t REG_STUCK_CHECK = 2'd2;

  localparam cnt_t BRAKE_DELAY_RST = 15'd200;
  localparam cnt_t MAX_RUN_RST     = 15'd20000;
  localparam cnt_t STUCK_CHECK_RST = 15'd1000;

  typedef logic [1:0] event_t;
  localparam event_t EV_NONE       = 2'd0;
  localparam event_t EV_NOT_MOVING = 2'd1;
  localparam event_t EV_MAX_RUN    = 2'd2;

  typedef struct packed {
    logic       power_relay;
    logic       direction_relay;
    event_t     event_code;
    logic [1:0] position;
  } result_t;

endpackage

FILE: rtl/door_motor_limit_controller.sv
// ----------------------------------------------------------------------------
// door_motor_limit_controller
// Motorized door control with two active-low limit switches and countdowns.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one item: a move command
// (in_func = 1) or one time tick (in_func = 0), with both switch levels.
// Each item yields exactly one result on the out_ channel: relay drives,
// event code and position.
// The result of an accepted item is registered. Throughput: one item per
// cycle while in_ready is high; the state update is a single pass of logic
// from the accepted item and the state registers to the result register.
// A two-entry output buffer (result register plus skid register) lets an item
// be taken while the previous result waits; in_ready drops only when both
// entries are full, so a stalled receiver holds the block after two items.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once;
// an unused index is ignored.
// Reset (rst_n low, synchronous) restores the default delays, powers the
// motor off, clears all countdowns and empties the output buffer.
// ----------------------------------------------------------------------------
module door_motor_limit_controller
  import dmlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CNT_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic                  in_go_up,
  input  logic                  in_top_switch,
  input  logic                  in_bottom_switch,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_power_relay,
  output logic                  out_direction_relay,
  output logic [1:0]            out_event_code,
  output logic [1:0]            out_position
);

  cnt_t brake_delay_r, max_run_r, stuck_check_r;

  logic power_on_r, power_on_nxt;
  logic direction_up_r, direction_up_nxt;
  logic travel_up_r, travel_up_nxt;
  logic stuck_pending_r, stuck_pending_nxt;
  logic brake_active_r, brake_active_nxt;
  logic stuck_armed_r, stuck_armed_nxt;
  logic maxrun_armed_r, maxrun_armed_nxt;
  cnt_t stuck_cnt_r, stuck_cnt_nxt;
  cnt_t maxrun_cnt_r, maxrun_cnt_nxt;
  cnt_t brake_cnt_r, brake_cnt_nxt;

  logic    top_closed, bot_closed, start_closed, stop_closed;
  event_t  ev;
  result_t res;

  result_t main_r, skid_r;
  logic    main_valid_r, skid_valid_r;
  logic    push, pop;

  assign in_ready = ~skid_valid_r;
  assign push     = in_valid & in_ready;
  assign pop      = main_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brake_delay_r <= BRAKE_DELAY_RST;
      max_run_r     <= MAX_RUN_RST;
      stuck_check_r <= STUCK_CHECK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BRAKE_DELAY: brake_delay_r <= cfg_wdata;
        REG_MAX_RUN:     max_run_r     <= cfg_wdata;
        REG_STUCK_CHECK: stuck_check_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    power_on_nxt      = power_on_r;
    direction_up_nxt  = direction_up_r;
    travel_up_nxt     = travel_up_r;
    stuck_pending_nxt = stuck_pending_r;
    brake_active_nxt  = brake_active_r;
    stuck_armed_nxt   = stuck_armed_r;
    maxrun_armed_nxt  = maxrun_armed_r;
    stuck_cnt_nxt     = stuck_cnt_r;
    maxrun_cnt_nxt    = maxrun_cnt_r;
    brake_cnt_nxt     = brake_cnt_r;
    ev                = EV_NONE;
    top_closed        = ~in_top_switch;
    bot_closed        = ~in_bottom_switch;
    start_closed      = 1'b0;
    stop_closed       = 1'b0;
    if (in_func) begin
      stuck_armed_nxt  = 1'b0;
      stuck_cnt_nxt    = '0;
      maxrun_armed_nxt = 1'b0;
      maxrun_cnt_nxt   = '0;
      travel_up_nxt    = in_go_up;
      start_closed     = in_go_up ? bot_closed : top_closed;
      stop_closed      = in_go_up ? top_closed : bot_closed;
      if (!stop_closed) begin
        direction_up_nxt = in_go_up;
        if (start_closed) begin
          stuck_pending_nxt = 1'b1;
          stuck_armed_nxt   = 1'b1;
          stuck_cnt_nxt     = stuck_check_r;
        end
        maxrun_armed_nxt = 1'b1;
        maxrun_cnt_nxt   = max_run_r;
        power_on_nxt     = 1'b1;
      end
    end else begin
      start_closed = travel_up_r ? bot_closed : top_closed;
      stop_closed  = travel_up_r ? top_closed : bot_closed;
      if (stuck_armed_nxt) begin
        if (stuck_cnt_nxt <= cnt_t'(1)) begin
          stuck_cnt_nxt     = '0;
          stuck_armed_nxt   = 1'b0;
          stuck_pending_nxt = 1'b0;
          if ((top_closed || bot_closed) && start_closed) begin
            power_on_nxt     = 1'b0;
            maxrun_armed_nxt = 1'b0;
            maxrun_cnt_nxt   = '0;
            ev               = EV_NOT_MOVING;
          end
        end else begin
          stuck_cnt_nxt = stuck_cnt_nxt - cnt_t'(1);
        end
      end
      if (maxrun_armed_nxt) begin
        if (maxrun_cnt_nxt <= cnt_t'(1)) begin
          stuck_armed_nxt  = 1'b0;
          stuck_cnt_nxt    = '0;
          maxrun_armed_nxt = 1'b0;
          maxrun_cnt_nxt   = '0;
          power_on_nxt     = 1'b0;
          brake_active_nxt = 1'b0;
          brake_cnt_nxt    = '0;
          ev               = EV_MAX_RUN;
        end else begin
          maxrun_cnt_nxt = maxrun_cnt_nxt - cnt_t'(1);
        end
      end
      if (brake_active_nxt) begin
        if (brake_cnt_nxt <= cnt_t'(1)) begin
          brake_cnt_nxt    = '0;
          stuck_armed_nxt  = 1'b0;
          stuck_cnt_nxt    = '0;
          maxrun_armed_nxt = 1'b0;
          maxrun_cnt_nxt   = '0;
          power_on_nxt     = 1'b0;
          brake_active_nxt = 1'b0;
        end else begin
          brake_cnt_nxt = brake_cnt_nxt - cnt_t'(1);
        end
      end
      if (!stuck_pending_nxt && !brake_active_nxt && power_on_nxt) begin
        if (stop_closed) begin
          brake_active_nxt = 1'b1;
          brake_cnt_nxt    = brake_delay_r;
        end
        if (start_closed) begin
          power_on_nxt = 1'b0;
          ev           = EV_NOT_MOVING;
        end
      end
    end
    res.power_relay     = power_on_nxt;
    res.direction_relay = direction_up_nxt;
    res.event_code      = ev;
    res.position        = {top_closed, bot_closed};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_on_r      <= 1'b0;
      direction_up_r  <= 1'b0;
      travel_up_r     <= 1'b0;
      stuck_pending_r <= 1'b0;
      brake_active_r  <= 1'b0;
      stuck_armed_r   <= 1'b0;
      maxrun_armed_r  <= 1'b0;
      stuck_cnt_r     <= '0;
      maxrun_cnt_r    <= '0;
      brake_cnt_r     <= '0;
    end else if (push) begin
      power_on_r      <= power_on_nxt;
      direction_up_r  <= direction_up_nxt;
      travel_up_r     <= travel_up_nxt;
      stuck_pending_r <= stuck_pending_nxt;
      brake_active_r  <= brake_active_nxt;
      stuck_armed_r   <= stuck_armed_nxt;
      maxrun_armed_r  <= maxrun_armed_nxt;
      stuck_cnt_r     <= stuck_cnt_nxt;
      maxrun_cnt_r    <= maxrun_cnt_nxt;
      brake_cnt_r     <= brake_cnt_nxt;
    end
  end

  // hold results in the result register, overflow into the skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        if (push) begin
          skid_r <= res;
        end
      end else if (push) begin
        main_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid           = main_valid_r;
  assign out_power_relay     = main_r.power_relay;
  assign out_direction_relay = main_r.direction_relay;
  assign out_event_code      = main_r.event_code;
  assign out_position        = main_r.position;

endmodule
